// File: src/cec_pkg.sv
// ----------------------------------------------------------------------------
// cec_pkg
// Shared types, constants and the month length table of the calendar/epoch
// converter.
// ----------------------------------------------------------------------------
package cec_pkg;

  localparam logic [11:0] EpochYear  = 12'd1970;
  localparam logic [11:0] LastYear   = 12'd2106;
  localparam logic [16:0] SecPerDay  = 17'd86400;
  localparam logic [16:0] SecPerHour = 17'd3600;
  localparam logic [16:0] SecPerMin  = 17'd60;

  // Reciprocals for the constant divisions. Each divisor is split into a power
  // of two and an odd part: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15.
  // The values are ceil(2^35 / 675), ceil(2^20 / 225) and ceil(2^14 / 15),
  // exact over the dividend ranges that occur.
  localparam logic [25:0] RecipDay  = 26'd50903317;
  localparam logic [12:0] RecipHour = 13'd4661;
  localparam logic [10:0] RecipMin  = 11'd1093;

  // Residues of the epoch year, used to track the leap rule while counting.
  localparam logic [1:0] EpochMod4   = 2'd2;
  localparam logic [6:0] EpochMod100 = 7'd70;
  localparam logic [8:0] EpochMod400 = 9'd370;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_DAY,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    DIV_SEL_DAY,
    DIV_SEL_HOUR,
    DIV_SEL_MIN
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     year_step;
    logic     month_step;
    logic     add_day;
    logic     mul;
    logic     add_tod;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_cap;
    div_sel_e cap_sel;
    logic     out_load;
  } cec_cmd_t;

  typedef struct packed {
    logic mode;
    logic bad;
    logic year_done;
    logic month_done;
    logic div_busy;
  } cec_sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                         len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
      default:                      len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: src/cec_div.sv
// ----------------------------------------------------------------------------
// cec_div
// Constant divider for the seconds split: the quotient comes from a
// reciprocal multiplication, the remainder from a multiply and subtract
// in the next cycle.
// ----------------------------------------------------------------------------
module cec_div import cec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  div_sel_e    sel_i,
  input  logic [31:0] dividend_i,
  output logic        busy_o,
  output logic [15:0] quot_o,
  output logic [16:0] rem_o
);

  logic        busy_q, busy_d;
  logic        step_q, step_d;
  logic [31:0] dvd_q, dvd_d;
  div_sel_e    sel_q, sel_d;
  logic [15:0] quot_q, quot_d;
  logic [16:0] rem_q, rem_d;

  logic [50:0] day_prod;
  logic [25:0] hour_prod;
  logic [20:0] min_prod;
  logic [15:0] quot_est;
  logic [16:0] divisor;
  logic [32:0] back_prod;

  always_comb begin
    // 25 by 26, 13 by 13 and 10 by 11 bit products.
    day_prod  = 51'(dvd_q[31:7]) * 51'(RecipDay);
    hour_prod = 26'(dvd_q[16:4]) * 26'(RecipHour);
    min_prod  = 21'(dvd_q[11:2]) * 21'(RecipMin);
    case (sel_q)
      DIV_SEL_HOUR: begin
        quot_est = 16'(hour_prod[25:20]);
        divisor  = SecPerHour;
      end
      DIV_SEL_MIN: begin
        quot_est = 16'(min_prod[20:14]);
        divisor  = SecPerMin;
      end
      default: begin
        quot_est = day_prod[50:35];
        divisor  = SecPerDay;
      end
    endcase
    back_prod = 33'(quot_q) * 33'(divisor);
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    dvd_d  = dvd_q;
    sel_d  = sel_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = 1'b0;
      dvd_d  = dividend_i;
      sel_d  = sel_i;
    end else if (busy_q) begin
      if (!step_q) begin
        quot_d = quot_est;
        step_d = 1'b1;
      end else begin
        rem_d  = 17'(33'(dvd_q) - back_prod);
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    sel_q  <= sel_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: src/cec_datapath.sv
// ----------------------------------------------------------------------------
// cec_datapath
// Working registers of the converter: input capture, year and month
// counters with leap tracking, the seconds divider, the day-to-seconds
// multiply and the result register.
// ----------------------------------------------------------------------------
module cec_datapath import cec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cec_cmd_t    cmd_i,
  output cec_sts_t    sts_o,
  input  logic        mode_i,
  input  logic [31:0] epoch_seconds_i,
  input  logic [11:0] year_in_i,
  input  logic [7:0]  month_in_i,
  input  logic [7:0]  day_in_i,
  input  logic [7:0]  hour_in_i,
  input  logic [7:0]  minute_in_i,
  input  logic [7:0]  second_in_i,
  output logic [31:0] epoch_out_o,
  output logic [11:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o,
  output logic        invalid_o
);

  logic        mode_q;
  logic [31:0] ts_q;
  logic [11:0] year_q;
  logic [7:0]  month_q, day_q, hour_q, minute_q, second_q;

  logic [11:0] y_q;
  logic [1:0]  mod4_q;
  logic [6:0]  mod100_q;
  logic [8:0]  mod400_q;
  logic [3:0]  m_q;
  logic [15:0] days_q;
  logic [4:0]  hr_q;
  logic [5:0]  mn_q, sc_q;
  logic [32:0] prod_q;
  logic [16:0] tod_q;
  logic [33:0] total_q;

  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  mon_len;
  logic        bad;
  logic        ovf;

  logic [31:0] div_dividend;
  logic        div_busy;
  logic [15:0] div_quot;
  logic [16:0] div_rem;

  assign leap     = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
  assign year_len = leap ? 9'd366 : 9'd365;
  assign mon_len  = month_len(m_q, leap);

  // Years past the last one always overflow 32 bits, so they are rejected here.
  assign bad = (year_q < EpochYear) || (year_q > LastYear) ||
               (month_q == 8'd0) || (month_q > 8'd12) ||
               (day_q == 8'd0) || (day_q > 8'd31) ||
               (hour_q > 8'd23) || (minute_q > 8'd59) || (second_q > 8'd59);
  assign ovf = bad || (total_q[33:32] != 2'd0);

  assign sts_o.mode       = mode_q;
  assign sts_o.bad        = bad;
  assign sts_o.year_done  = mode_q ? (days_q < 16'(year_len)) : (y_q == year_q);
  assign sts_o.month_done = mode_q ? ((m_q == 4'd12) || (days_q < 16'(mon_len)))
                                   : (m_q == month_q[3:0]);
  assign sts_o.div_busy   = div_busy;

  // The hour and minute splits work on the remainder of the previous split.
  always_comb begin
    case (cmd_i.div_sel)
      DIV_SEL_DAY: div_dividend = ts_q;
      default:     div_dividend = 32'(div_rem);
    endcase
  end

  cec_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .sel_i      (cmd_i.div_sel),
    .dividend_i (div_dividend),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      ts_q     <= epoch_seconds_i;
      year_q   <= year_in_i;
      month_q  <= month_in_i;
      day_q    <= day_in_i;
      hour_q   <= hour_in_i;
      minute_q <= minute_in_i;
      second_q <= second_in_i;
      y_q      <= EpochYear;
      mod4_q   <= EpochMod4;
      mod100_q <= EpochMod100;
      mod400_q <= EpochMod400;
      m_q      <= 4'd1;
      days_q   <= '0;
    end else if (cmd_i.year_step) begin
      days_q   <= mode_q ? days_q - 16'(year_len) : days_q + 16'(year_len);
      y_q      <= y_q + 12'd1;
      mod4_q   <= mod4_q + 2'd1;
      mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
      mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
    end else if (cmd_i.month_step) begin
      days_q <= mode_q ? days_q - 16'(mon_len) : days_q + 16'(mon_len);
      m_q    <= m_q + 4'd1;
    end else if (cmd_i.add_day) begin
      days_q <= days_q + 16'(day_q[4:0]) - 16'd1;
    end else if (cmd_i.div_cap && (cmd_i.cap_sel == DIV_SEL_DAY)) begin
      days_q <= div_quot;
    end

    if (cmd_i.div_cap) begin
      case (cmd_i.cap_sel)
        DIV_SEL_HOUR: hr_q <= div_quot[4:0];
        DIV_SEL_MIN: begin
          mn_q <= div_quot[5:0];
          sc_q <= div_rem[5:0];
        end
        default: ;
      endcase
    end

    if (cmd_i.mul) begin
      prod_q <= 33'(days_q) * 33'(SecPerDay);
      tod_q  <= 17'(hour_q[4:0]) * SecPerHour + 17'(minute_q[5:0]) * SecPerMin
              + 17'(second_q[5:0]);
    end
    if (cmd_i.add_tod) begin
      total_q <= 34'(prod_q) + 34'(tod_q);
    end

    if (cmd_i.out_load) begin
      if (mode_q) begin
        epoch_out_o  <= '0;
        invalid_o    <= 1'b0;
        year_out_o   <= y_q;
        month_out_o  <= m_q;
        day_out_o    <= days_q[4:0] + 5'd1;
        hour_out_o   <= hr_q;
        minute_out_o <= mn_q;
        second_out_o <= sc_q;
      end else begin
        epoch_out_o  <= ovf ? 32'd0 : total_q[31:0];
        invalid_o    <= ovf;
        year_out_o   <= '0;
        month_out_o  <= '0;
        day_out_o    <= '0;
        hour_out_o   <= '0;
        minute_out_o <= '0;
        second_out_o <= '0;
      end
    end
  end

endmodule

// File: src/cec_ctrl.sv
// ----------------------------------------------------------------------------
// cec_ctrl
// Sequencer of the converter: handshakes, step commands to the datapath and
// the valid bit of the result register.
// ----------------------------------------------------------------------------
module cec_ctrl import cec_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  cec_sts_t sts_i,
  output cec_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (sts_i.mode) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SEL_DAY;
          state_d         = ST_DIV_DAY;
        end else if (sts_i.bad) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_YEAR;
        end
      end
      ST_DIV_DAY: begin
        if (!sts_i.div_busy) begin
          cmd_o.div_cap   = 1'b1;
          cmd_o.cap_sel   = DIV_SEL_DAY;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SEL_HOUR;
          state_d         = ST_DIV_HOUR;
        end
      end
      ST_DIV_HOUR: begin
        if (!sts_i.div_busy) begin
          cmd_o.div_cap   = 1'b1;
          cmd_o.cap_sel   = DIV_SEL_HOUR;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SEL_MIN;
          state_d         = ST_DIV_MIN;
        end
      end
      ST_DIV_MIN: begin
        if (!sts_i.div_busy) begin
          cmd_o.div_cap = 1'b1;
          cmd_o.cap_sel = DIV_SEL_MIN;
          state_d       = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sts_i.year_done) begin
          state_d = ST_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts_i.month_done) begin
          state_d = sts_i.mode ? ST_DONE : ST_DAY;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      ST_DAY: begin
        cmd_o.add_day = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add_tod = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        // The result register may still hold the previous transaction.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/calendar_epoch_converter.sv
// ----------------------------------------------------------------------------
// calendar_epoch_converter
// Converts between a Gregorian date-time and 32-bit Unix seconds.
// ----------------------------------------------------------------------------
// Usage: present an item on the input channel (valid/ready); mode_i selects
// date fields to seconds (0) or seconds to date fields (1). Each transaction
// yields exactly one result on the output channel (valid/ready).
// One item is worked on at a time; in_ready_o is high only while idle.
// A date-to-seconds item with a field out of range skips the year and month
// steps and goes straight to the result.
// Mode 1 first splits the seconds count into days, hours, minutes and seconds
// with three divisions by reciprocal multiplication; both modes then step one
// year and one month per cycle.
// The next item can be accepted in the cycle after the result is loaded, so
// no new item is taken before the last one is loaded into the result register.
// The result sits in an output register, so a new item is accepted while the
// previous result waits; a finished item waits there only if the receiver
// still stalls the older result.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module calendar_epoch_converter import cec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [31:0] epoch_seconds_i,
  input  logic [11:0] year_in_i,
  input  logic [7:0]  month_in_i,
  input  logic [7:0]  day_in_i,
  input  logic [7:0]  hour_in_i,
  input  logic [7:0]  minute_in_i,
  input  logic [7:0]  second_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] epoch_out_o,
  output logic [11:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o,
  output logic        invalid_o
);

  cec_cmd_t cmd;
  cec_sts_t sts;

  cec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cec_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .epoch_seconds_i (epoch_seconds_i),
    .year_in_i       (year_in_i),
    .month_in_i      (month_in_i),
    .day_in_i        (day_in_i),
    .hour_in_i       (hour_in_i),
    .minute_in_i     (minute_in_i),
    .second_in_i     (second_in_i),
    .epoch_out_o     (epoch_out_o),
    .year_out_o      (year_out_o),
    .month_out_o     (month_out_o),
    .day_out_o       (day_out_o),
    .hour_out_o      (hour_out_o),
    .minute_out_o    (minute_out_o),
    .second_out_o    (second_out_o),
    .invalid_o       (invalid_o)
  );

  // Only one transaction is in flight inside the converter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a conversion is in progress");

  // A rejected date carries a zero seconds count and no date fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> epoch_out_o == 32'd0 && month_out_o == 4'd0)
    else $error("invalid result with nonzero fields");

  // A split result has a real month and day and no seconds count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && month_out_o != 4'd0 |->
      epoch_out_o == 32'd0 && !invalid_o && day_out_o != 5'd0 && month_out_o <= 4'd12)
    else $error("inconsistent date result");

endmodule

// File: tb/calendar_epoch_converter_tb.sv
// ----------------------------------------------------------------------------
// calendar_epoch_converter_tb
// Self-checking testbench for the calendar/epoch converter. Date fields are
// converted to seconds and seconds back to date fields. A behavioral
// predictor in the scoreboard works out every result in order. Directed
// corner cases come first, then random date-time and seconds traffic. Both
// channels see random gaps and stalls, and one long output hold-off backs up
// the block until it stops taking input.
// ----------------------------------------------------------------------------
module calendar_epoch_converter_tb;
  import cec_pkg::*;

  localparam logic        MODE_TO_EPOCH = 1'b0;
  localparam logic        MODE_TO_DATE  = 1'b1;
  localparam int unsigned N_RANDOM      = 1830;
  localparam int unsigned HOLD_OFF_AT   = 400;
  localparam int unsigned HOLD_OFF_LEN  = 600;
  localparam int unsigned TAIL_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 3000000;

  typedef struct packed {
    logic        mode;
    logic [31:0] epoch_seconds;
    logic [11:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } conv_req_t;

  typedef struct packed {
    logic [31:0] epoch_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        invalid;
  } conv_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        mode_i;
  logic [31:0] epoch_seconds_i;
  logic [11:0] year_in_i;
  logic [7:0]  month_in_i;
  logic [7:0]  day_in_i;
  logic [7:0]  hour_in_i;
  logic [7:0]  minute_in_i;
  logic [7:0]  second_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] epoch_out_o;
  logic [11:0] year_out_o;
  logic [3:0]  month_out_o;
  logic [4:0]  day_out_o;
  logic [4:0]  hour_out_o;
  logic [5:0]  minute_out_o;
  logic [5:0]  second_out_o;
  logic        invalid_o;

  bit          no_idle;
  int unsigned cycle_cnt;

  calendar_epoch_converter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .epoch_seconds_i(epoch_seconds_i),
    .year_in_i      (year_in_i),
    .month_in_i     (month_in_i),
    .day_in_i       (day_in_i),
    .hour_in_i      (hour_in_i),
    .minute_in_i    (minute_in_i),
    .second_in_i    (second_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .epoch_out_o    (epoch_out_o),
    .year_out_o     (year_out_o),
    .month_out_o    (month_out_o),
    .day_out_o      (day_out_o),
    .hour_out_o     (hour_out_o),
    .minute_out_o   (minute_out_o),
    .second_out_o   (second_out_o),
    .invalid_o      (invalid_o)
  );

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_day_count(int unsigned y, int unsigned m);
    case (m)
      2: return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int unsigned days_in_year(int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic conv_res_t predict_conversion(conv_req_t q);
    conv_res_t       r;
    longint unsigned days;
    longint unsigned total;
    int unsigned     y;
    int unsigned     m;
    int unsigned     day_left;
    int unsigned     sod;
    r = '0;
    if (q.mode == MODE_TO_EPOCH) begin
      if (q.year < EpochYear || q.month < 1 || q.month > 12 || q.day < 1 || q.day > 31 ||
          q.hour > 23 || q.minute > 59 || q.second > 59) begin
        r.invalid = 1'b1;
      end else begin
        days = 0;
        for (y = EpochYear; y < q.year; y++) days += days_in_year(y);
        for (m = 1; m < q.month; m++) days += month_day_count(q.year, m);
        // Days past the end of the month simply carry into the next one.
        days += q.day - 1;
        total = days * 86400 + longint'(q.hour) * 3600 + longint'(q.minute) * 60 +
                longint'(q.second);
        if (total > 64'hFFFF_FFFF) r.invalid = 1'b1;
        else r.epoch_out = total[31:0];
      end
    end else begin
      day_left = q.epoch_seconds / 86400;
      sod = q.epoch_seconds % 86400;
      y = EpochYear;
      while (day_left >= days_in_year(y)) begin
        day_left -= days_in_year(y);
        y++;
      end
      m = 1;
      while (m < 12 && day_left >= month_day_count(y, m)) begin
        day_left -= month_day_count(y, m);
        m++;
      end
      r.year_out   = y[11:0];
      r.month_out  = m[3:0];
      r.day_out    = 5'(day_left + 1);
      r.hour_out   = 5'(sod / 3600);
      r.minute_out = 6'((sod % 3600) / 60);
      r.second_out = 6'(sod % 60);
    end
    return r;
  endfunction

  class conversion_scoreboard;
    conv_res_t   expected_q[$];
    int unsigned accepted;
    int unsigned checked;
    int unsigned errors;
    int unsigned n_to_epoch;
    int unsigned n_rejected;
    int unsigned n_to_date;

    function void note_input(conv_req_t q);
      conv_res_t r;
      r = predict_conversion(q);
      expected_q.push_back(r);
      accepted++;
      if (q.mode == MODE_TO_DATE) n_to_date++;
      else begin
        n_to_epoch++;
        if (r.invalid) n_rejected++;
      end
    endfunction

    function void compare_field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s mismatch: expected %0d, actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(conv_res_t a);
      conv_res_t e;
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending: epoch_out=%0d year_out=%0d",
               a.epoch_out, a.year_out);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      compare_field("epoch_out", e.epoch_out, a.epoch_out);
      compare_field("year_out", e.year_out, a.year_out);
      compare_field("month_out", e.month_out, a.month_out);
      compare_field("day_out", e.day_out, a.day_out);
      compare_field("hour_out", e.hour_out, a.hour_out);
      compare_field("minute_out", e.minute_out, a.minute_out);
      compare_field("second_out", e.second_out, a.second_out);
      compare_field("invalid", e.invalid, a.invalid);
    endfunction
  endclass

  conversion_scoreboard sb;

  // Mostly back-to-back or short gaps, with an occasional long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Ignored fields always carry random values.
  function automatic conv_req_t noise_fields(logic mode);
    conv_req_t q;
    q.mode          = mode;
    q.epoch_seconds = $urandom;
    q.year          = 12'($urandom);
    q.month         = 8'($urandom);
    q.day           = 8'($urandom);
    q.hour          = 8'($urandom);
    q.minute        = 8'($urandom);
    q.second        = 8'($urandom);
    return q;
  endfunction

  function automatic conv_req_t date_item(int unsigned y, int unsigned mo, int unsigned d,
                                          int unsigned h, int unsigned mi, int unsigned s);
    conv_req_t q;
    q        = noise_fields(MODE_TO_EPOCH);
    q.year   = 12'(y);
    q.month  = 8'(mo);
    q.day    = 8'(d);
    q.hour   = 8'(h);
    q.minute = 8'(mi);
    q.second = 8'(s);
    return q;
  endfunction

  function automatic conv_req_t epoch_item(logic [31:0] ts);
    conv_req_t q;
    q               = noise_fields(MODE_TO_DATE);
    q.epoch_seconds = ts;
    return q;
  endfunction

  function automatic conv_req_t random_date();
    return date_item($urandom_range(1970, 2106), $urandom_range(1, 12), $urandom_range(1, 31),
                     $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  function automatic conv_req_t random_item();
    conv_req_t   q;
    conv_res_t   r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      q = random_date();
    end else if (pick < 55) begin
      q = random_date();
      case ($urandom_range(0, 6))
        0: q.year = 12'($urandom);
        1: q.month = 8'($urandom);
        2: q.day = 8'($urandom);
        3: q.hour = 8'($urandom);
        4: q.minute = 8'($urandom);
        5: q.second = 8'($urandom);
        default: q = noise_fields(MODE_TO_EPOCH);
      endcase
    end else if (pick < 85) begin
      q = epoch_item($urandom);
    end else begin
      // Land right on or just before the first second of a month.
      r = predict_conversion(date_item($urandom_range(1970, 2106), $urandom_range(1, 12),
                                       1, 0, 0, 0));
      if (r.invalid) q = epoch_item($urandom);
      else q = epoch_item(r.epoch_out - $urandom_range(0, 1));
    end
    return q;
  endfunction

  task automatic send_item(conv_req_t q);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i          = q.mode;
    epoch_seconds_i = q.epoch_seconds;
    year_in_i       = q.year;
    month_in_i      = q.month;
    day_in_i        = q.day;
    hour_in_i       = q.hour;
    minute_in_i     = q.minute;
    second_in_i     = q.second;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(q);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             sb.expected_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{epoch_out: epoch_out_o, year_out: year_out_o, month_out: month_out_o,
                        day_out: day_out_o, hour_out: hour_out_o, minute_out: minute_out_o,
                        second_out: second_out_o, invalid: invalid_o});
    end
  end

  // Output side: random stalls, plus one long hold-off so the block backs up
  // and drops in_ready_o while transactions keep being offered.
  initial begin
    bit          held_off;
    int unsigned stall_left;
    held_off    = 1'b0;
    stall_left  = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && sb.accepted >= HOLD_OFF_AT) begin
        held_off    = 1'b1;
        out_ready_i = 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk_i);
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    conv_req_t directed_q[$];
    sb              = new();
    cycle_cnt       = 0;
    no_idle         = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    mode_i          = MODE_TO_EPOCH;
    epoch_seconds_i = '0;
    year_in_i       = '0;
    month_in_i      = '0;
    day_in_i        = '0;
    hour_in_i       = '0;
    minute_in_i     = '0;
    second_in_i     = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_q.push_back(date_item(1970, 1, 1, 0, 0, 0));
    directed_q.push_back(date_item(2106, 2, 7, 6, 28, 15));    // largest count that fits
    directed_q.push_back(date_item(2106, 2, 7, 6, 28, 16));    // one second too far
    directed_q.push_back(date_item(4095, 12, 31, 23, 59, 59));
    directed_q.push_back(date_item(1969, 12, 31, 23, 59, 59));
    directed_q.push_back(date_item(0, 1, 1, 0, 0, 0));
    directed_q.push_back(date_item(2000, 0, 1, 0, 0, 0));
    directed_q.push_back(date_item(2000, 13, 1, 0, 0, 0));
    directed_q.push_back(date_item(2000, 1, 0, 0, 0, 0));
    directed_q.push_back(date_item(2000, 1, 32, 0, 0, 0));
    directed_q.push_back(date_item(2000, 1, 1, 24, 0, 0));
    directed_q.push_back(date_item(2000, 1, 1, 0, 60, 0));
    directed_q.push_back(date_item(2000, 1, 1, 0, 0, 60));
    directed_q.push_back(date_item(4095, 255, 255, 255, 255, 255));
    directed_q.push_back(date_item(2001, 2, 31, 12, 0, 0));    // rolls into March
    directed_q.push_back(date_item(2000, 2, 29, 23, 59, 59));
    directed_q.push_back(date_item(2100, 2, 29, 0, 0, 0));     // 2100 is not a leap year
    directed_q.push_back(date_item(2000, 12, 31, 23, 59, 59));
    directed_q.push_back(epoch_item(32'd0));
    directed_q.push_back(epoch_item(32'hFFFF_FFFF));
    directed_q.push_back(epoch_item(32'd951782400));
    directed_q.push_back(epoch_item(32'd978307199));
    directed_q.push_back(epoch_item(32'd4107542399));
    directed_q.push_back(epoch_item(32'd86399));
    foreach (directed_q[i]) send_item(directed_q[i]);

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 700 && i < 900);
      send_item(random_item());
    end
    no_idle = 1'b0;
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("tb: %0d date-to-seconds transactions (%0d rejected), %0d seconds-to-date",
             sb.n_to_epoch, sb.n_rejected, sb.n_to_date);
    $display("tb: %0d results checked in %0d cycles, %0d mismatches",
             sb.checked, cycle_cnt, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
